[rtl/tfcpu_pkg.sv]
// Shared types, constants and helper functions for the four-bit processor core.
`default_nettype none

package tfcpu_pkg;

  localparam int DEF_REG_COUNT     = 15;
  localparam int DEF_PROGRAM_DEPTH = 16;
  localparam int DEF_DATA_WIDTH    = 4;

  localparam int CMD_W       = 2;
  localparam int OP_W        = 3;
  localparam int FIELD_W     = 4;
  localparam int WORD_W      = OP_W + 2 * FIELD_W;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_EXEC    = 2'd1,
    CMD_STEP    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MOV  = 3'd2,
    OP_IMMD = 3'd3,
    OP_JZ   = 3'd4,
    OP_AND  = 3'd5,
    OP_OR   = 3'd6,
    OP_NOT  = 3'd7
  } op_t;

  // classified request, as queued between front and back
  typedef struct packed {
    logic               write_store;
    logic               fetch;
    logic               run;
    logic [FIELD_W-1:0] load_address;
    op_t                op;
    logic [FIELD_W-1:0] field_a;
    logic [FIELD_W-1:0] field_b;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] pc_now;
    logic [FIELD_W-1:0] reg_zero;
    logic               dest_valid;
    logic [FIELD_W-1:0] dest_index;
    logic [FIELD_W-1:0] dest_value;
    logic               jumped;
    logic               bad_index;
  } result_t;

  // v modulo depth for 4-bit v and depth >= 2: at most seven subtractions needed
  function automatic logic [FIELD_W-1:0] wrap_index(input logic [FIELD_W-1:0] v,
                                                    input logic [FIELD_W:0] depth);
    logic [FIELD_W:0] r;
    r = {1'b0, v};
    for (int i = 0; i < 8; i++) begin
      if (r >= depth) begin
        r = r - depth;
      end
    end
    return r[FIELD_W-1:0];
  endfunction

  // store word: op on top, then field_a, then field_b
  function automatic logic [WORD_W-1:0] pack_word(input op_t o, input logic [FIELD_W-1:0] a,
                                                  input logic [FIELD_W-1:0] b);
    return {o, a, b};
  endfunction

endpackage

`default_nettype wire

[rtl/tfcpu_front.sv]
// Front end: classifies an incoming command into a queued request.
`default_nettype none

module tfcpu_front import tfcpu_pkg::*; (
  input  logic [CMD_W-1:0]   command,
  input  logic [FIELD_W-1:0] load_address,
  input  logic [OP_W-1:0]    op,
  input  logic [FIELD_W-1:0] field_a,
  input  logic [FIELD_W-1:0] field_b,
  output req_t               req
);

  cmd_t cmd;

  assign cmd = cmd_t'(command);

  always_comb begin
    req.load_address = load_address;
    req.op           = op_t'(op);
    req.field_a      = field_a;
    req.field_b      = field_b;
    req.write_store  = 1'b0;
    req.fetch        = 1'b0;
    req.run          = 1'b0;
    unique case (cmd)
      CMD_LOAD: begin
        req.write_store = 1'b1;
      end
      CMD_EXEC: begin
        req.run = 1'b1;
      end
      CMD_STEP: begin
        req.run   = 1'b1;
        req.fetch = 1'b1;
      end
      CMD_RESTART: begin
        // PC clear only
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/tfcpu_fifo.sv]
// Short request queue between the front and back ends.
`default_nettype none

module tfcpu_fifo import tfcpu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t wr_data,
  output logic full,
  input  logic pop,
  output req_t rd_data,
  output logic empty
);

  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = QPTR_W + 1;

  req_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push_ok;
  logic              pop_ok;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
        count <= count + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/tfcpu_back.sv]
// Back end: fetch, register read, execute and the result register.
`default_nettype none

module tfcpu_back import tfcpu_pkg::*; #(
  parameter int REG_COUNT     = DEF_REG_COUNT,
  parameter int PROGRAM_DEPTH = DEF_PROGRAM_DEPTH,
  parameter int DATA_WIDTH    = DEF_DATA_WIDTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  req_t    q_data,
  output logic    q_pop,
  output logic    out_empty,
  input  logic    out_pop,
  output result_t res
);

  localparam int IDX_W = $clog2(REG_COUNT);
  localparam int PC_W  = $clog2(PROGRAM_DEPTH);
  localparam int FW1   = FIELD_W + 1;
  localparam logic [FW1-1:0] REG_LIMIT = FW1'(REG_COUNT);
  localparam logic [FW1-1:0] DEPTH_LIM = FW1'(PROGRAM_DEPTH);

  // architectural state
  logic [FIELD_W-1:0]    pc;
  logic [WORD_W-1:0]     store [PROGRAM_DEPTH];
  logic [DATA_WIDTH-1:0] mem [REG_COUNT];
  logic [REG_COUNT-1:0]  reg_valid;
  logic [DATA_WIDTH-1:0] r0;

  // execute stage
  logic                  e_valid;
  logic                  e_run;
  op_t                   e_op;
  logic [FIELD_W-1:0]    e_fa;
  logic [FIELD_W-1:0]    e_fb;
  logic                  e_bad;
  logic [DATA_WIDTH-1:0] e_x;
  logic [DATA_WIDTH-1:0] e_y;

  logic                  out_valid;

  // control
  logic                  out_free;
  logic                  e_adv;
  logic                  e_take;

  // queue head decode
  logic [FIELD_W-1:0]    pc_fwd;
  logic [WORD_W-1:0]     word;
  op_t                   h_op;
  logic [FIELD_W-1:0]    h_fa;
  logic [FIELD_W-1:0]    h_fb;
  logic                  h_fa_ok;
  logic                  h_fb_ok;
  logic                  h_bad;
  logic [IDX_W-1:0]      ra;
  logic [IDX_W-1:0]      rb;
  logic [FIELD_W-1:0]    ld_addr;

  // execute results
  logic                  e_dv;
  logic [FIELD_W-1:0]    e_di;
  logic [DATA_WIDTH-1:0] e_dval;
  logic                  e_jmp;
  logic [FIELD_W-1:0]    e_pc_after;
  logic [FIELD_W-1:0]    pc_inc;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [DATA_WIDTH-1:0] r0_after;

  assign out_free  = !out_valid || out_pop;
  assign e_adv     = e_valid && out_free;
  assign e_take    = !e_valid || e_adv;
  assign q_pop     = !q_empty && e_take;
  assign out_empty = !out_valid;

  // PC as the head request sees it: after the request now in execute
  assign pc_fwd = e_valid ? e_pc_after : pc;
  assign word   = store[pc_fwd[PC_W-1:0]];

  always_comb begin
    if (q_data.fetch) begin
      h_op = op_t'(word[2*FIELD_W +: OP_W]);
      h_fa = word[FIELD_W +: FIELD_W];
      h_fb = word[0 +: FIELD_W];
    end else begin
      h_op = q_data.op;
      h_fa = q_data.field_a;
      h_fb = q_data.field_b;
    end
  end

  assign h_fa_ok = (FW1'(h_fa) < REG_LIMIT);
  assign h_fb_ok = (FW1'(h_fb) < REG_LIMIT);
  assign ra      = h_fa_ok ? h_fa[IDX_W-1:0] : '0;
  assign rb      = h_fb_ok ? h_fb[IDX_W-1:0] : '0;
  assign ld_addr = wrap_index(q_data.load_address, DEPTH_LIM);

  always_comb begin
    unique case (h_op)
      OP_IMMD: h_bad = !h_fa_ok;
      OP_JZ:   h_bad = !h_fb_ok;
      default: h_bad = !(h_fa_ok && h_fb_ok);
    endcase
  end

  // execute
  assign pc_inc = (FW1'(pc) + FW1'(1) == DEPTH_LIM) ? '0 : pc + FIELD_W'(1);

  always_comb begin
    e_dv       = 1'b0;
    e_di       = '0;
    e_dval     = '0;
    e_jmp      = 1'b0;
    e_pc_after = '0;
    if (e_run) begin
      if (!e_bad) begin
        unique case (e_op)
          OP_ADD: begin
            e_dv = 1'b1; e_dval = e_x + e_y;
          end
          OP_SUB: begin
            e_dv = 1'b1; e_dval = e_x - e_y;
          end
          OP_AND: begin
            e_dv = 1'b1; e_dval = e_x & e_y;
          end
          OP_OR: begin
            e_dv = 1'b1; e_dval = e_x | e_y;
          end
          OP_MOV: begin
            e_dv = 1'b1; e_di = e_fb; e_dval = e_x;
          end
          OP_NOT: begin
            e_dv = 1'b1; e_di = e_fb; e_dval = ~e_x;
          end
          OP_IMMD: begin
            e_dv = 1'b1; e_di = e_fa; e_dval = DATA_WIDTH'(e_fb);
          end
          OP_JZ: begin
            e_jmp = (e_y == '0);
          end
        endcase
      end
      e_pc_after = e_jmp ? wrap_index(e_fa, DEPTH_LIM) : pc_inc;
    end
  end

  assign we       = e_adv && e_dv;
  assign waddr    = e_di[IDX_W-1:0];
  assign r0_after = (e_dv && e_di == '0) ? e_dval : r0;

  // register file
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= e_dval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_valid <= '0;
      r0        <= '0;
    end else if (we) begin
      reg_valid[waddr] <= 1'b1;
      r0               <= r0_after;
    end
  end

  // operand read, write-first against the retiring request
  always_ff @(posedge clk) begin
    if (q_pop) begin
      e_x   <= (we && waddr == ra) ? e_dval : (reg_valid[ra] ? mem[ra] : '0);
      e_y   <= (we && waddr == rb) ? e_dval : (reg_valid[rb] ? mem[rb] : '0);
      e_run <= q_data.run;
      e_op  <= h_op;
      e_fa  <= h_fa;
      e_fb  <= h_fb;
      e_bad <= q_data.run && h_bad;
    end
  end

  // program store and PC
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PROGRAM_DEPTH; i++) begin
        store[i] <= '0;
      end
    end else if (q_pop && q_data.write_store) begin
      store[ld_addr[PC_W-1:0]] <= pack_word(q_data.op, q_data.field_a, q_data.field_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (e_adv) begin
      pc <= e_pc_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (e_take) begin
        e_valid <= q_pop;
      end
      if (e_adv) begin
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e_adv) begin
      res.pc_now     <= e_pc_after;
      res.reg_zero   <= r0_after[FIELD_W-1:0];
      res.dest_valid <= e_dv;
      res.dest_index <= e_di;
      res.dest_value <= e_dval[FIELD_W-1:0];
      res.jumped     <= e_jmp;
      res.bad_index  <= e_bad;
    end
  end

`ifndef NO_ASSERTIONS
  a_pc_in_store: assert property (@(posedge clk) disable iff (rst)
    FW1'(pc) < DEPTH_LIM)
    else $error("PC outside program store");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    we |-> FW1'(e_di) < REG_LIMIT)
    else $error("register write beyond register file");

  a_exec_holds: assert property (@(posedge clk) disable iff (rst)
    e_valid && !out_free |=> e_valid && $stable(e_op) && $stable(e_x) && $stable(e_y))
    else $error("stalled execute request lost or changed");

  a_dropped_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(res.bad_index && (res.dest_valid || res.jumped)))
    else $error("dropped instruction has side effects");
`endif

endmodule

`default_nettype wire

[rtl/tiny_four_bit_cpu_core_top.sv]
// Top level of the four-bit processor core: front end, request queue, back end.
// Usage:
//   Requests enter through a queue-style port: a request is taken at a rising
//   edge with push high and full low. Each request carries a command (load a
//   program word, execute the given instruction, step from the program
//   store at the PC, or restart the PC) plus the instruction fields.
//   Every request yields exactly one result, in order. The oldest result
//   sits on the result ports while empty is low and is taken at an edge
//   with pop high and empty low.
// Path: a taken request passes through the queue, then the operand read into
//   execute, then the result register.
// Throughput: one request per cycle sustained while results are popped. The
//   front classifies the command into a two-entry queue; the back pops it,
//   fetches from the program store at the forwarded PC, reads both operands
//   from the register file into the execute stage, and retires into the result
//   register, so fetch, read and execute of consecutive requests overlap.
// Stalls: while the result is not popped the execute stage holds, the
//   queue fills, and full rises once both queue entries are occupied;
//   nothing is dropped.
// Reset (rst, synchronous, active high): clears registers, PC, program store
//   and all pipeline and queue state.
`default_nettype none

module tiny_four_bit_cpu_core_top import tfcpu_pkg::*; #(
  parameter int REG_COUNT     = DEF_REG_COUNT,
  parameter int PROGRAM_DEPTH = DEF_PROGRAM_DEPTH,
  parameter int DATA_WIDTH    = DEF_DATA_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  // request side
  input  logic               push,
  output logic               full,
  input  logic [CMD_W-1:0]   command,
  input  logic [FIELD_W-1:0] load_address,
  input  logic [OP_W-1:0]    op,
  input  logic [FIELD_W-1:0] field_a,
  input  logic [FIELD_W-1:0] field_b,
  // result side
  output logic               empty,
  input  logic               pop,
  output logic [FIELD_W-1:0] pc_now,
  output logic [FIELD_W-1:0] reg_zero,
  output logic               dest_valid,
  output logic [FIELD_W-1:0] dest_index,
  output logic [FIELD_W-1:0] dest_value,
  output logic               jumped,
  output logic               bad_index
);

  req_t    req;      // classified request from the front
  req_t    q_head;   // oldest queued request
  logic    q_empty;
  logic    q_pop;
  result_t res;

  tfcpu_front u_front (
    .command      (command),
    .load_address (load_address),
    .op           (op),
    .field_a      (field_a),
    .field_b      (field_b),
    .req          (req)
  );

  // decouples the front from a stalled back end
  tfcpu_fifo u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (req),
    .full    (full),
    .pop     (q_pop),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  tfcpu_back #(
    .REG_COUNT     (REG_COUNT),
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .DATA_WIDTH    (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .out_empty (empty),
    .out_pop   (pop),
    .res       (res)
  );

  // result fields straight from the result register
  assign pc_now     = res.pc_now;
  assign reg_zero   = res.reg_zero;
  assign dest_valid = res.dest_valid;
  assign dest_index = res.dest_index;
  assign dest_value = res.dest_value;
  assign jumped     = res.jumped;
  assign bad_index  = res.bad_index;

endmodule

`default_nettype wire
